/* rtl/rv64d_pkg.sv */
`timescale 1ns / 1ps
package rv64d_pkg;

	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] F7_ALT     = 7'b0100000;
	localparam logic [5:0] F6_SRAI    = 6'b010000;

	localparam logic [5:0] KIND_SUB   = 6'd1;
	localparam logic [5:0] KIND_SRA   = 6'd7;
	localparam logic [5:0] KIND_SLLI  = 6'd14;
	localparam logic [5:0] KIND_SRLI  = 6'd15;
	localparam logic [5:0] KIND_SRAI  = 6'd16;
	localparam logic [5:0] KIND_LOAD0 = 6'd19;
	localparam logic [5:0] KIND_JALR  = 6'd26;
	localparam logic [5:0] KIND_STOR0 = 6'd27;
	localparam logic [5:0] KIND_JAL   = 6'd31;
	localparam logic [5:0] KIND_LUI   = 6'd32;
	localparam logic [5:0] KIND_UNREC = 6'd39;

	localparam int LINE_W = 20;

	typedef struct packed {
		logic [5:0]        kind;
		logic signed [31:0] imm;
		logic              branch;
		logic signed [LINE_W-1:0] offset;
	} dec_t;

	function automatic logic [5:0] r_kind(input logic [2:0] f3);
		logic [5:0] k;
		case (f3)
			3'd0: k = 6'd0;
			3'd1: k = 6'd5;
			3'd2: k = 6'd8;
			3'd3: k = 6'd9;
			3'd4: k = 6'd2;
			3'd5: k = 6'd6;
			3'd6: k = 6'd3;
			default: k = 6'd4;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] i_kind(input logic [2:0] f3);
		logic [5:0] k;
		case (f3)
			3'd0: k = 6'd10;
			3'd2: k = 6'd17;
			3'd3: k = 6'd18;
			3'd4: k = 6'd11;
			3'd6: k = 6'd12;
			3'd7: k = 6'd13;
			default: k = KIND_UNREC;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] b_kind(input logic [2:0] f3);
		logic [5:0] k;
		case (f3)
			3'd0: k = 6'd33;
			3'd1: k = 6'd34;
			3'd4: k = 6'd35;
			3'd5: k = 6'd36;
			3'd6: k = 6'd37;
			3'd7: k = 6'd38;
			default: k = KIND_UNREC;
		endcase
		return k;
	endfunction

endpackage

/* rtl/rv64d_decode.sv */
`timescale 1ns / 1ps
module rv64d_decode (
	input  logic [31:0]     instruction,
	output rv64d_pkg::dec_t dec
);
	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	logic [5:0] f6;
	logic signed [20:0] j_imm;
	logic signed [12:0] b_imm;
	logic signed [31:0] off_full;

	assign opc = instruction[6:0];
	assign f3  = instruction[14:12];
	assign f7  = instruction[31:25];
	assign f6  = instruction[31:26];
	assign j_imm = {instruction[31], instruction[19:12], instruction[20],
		instruction[30:21], 1'b0};
	assign b_imm = {instruction[31], instruction[7], instruction[30:25],
		instruction[11:8], 1'b0};

	always_comb begin
		dec.kind   = rv64d_pkg::KIND_UNREC;
		dec.imm    = '0;
		dec.branch = 1'b0;
		case (opc)
			rv64d_pkg::OPC_OP: begin
				if (f7 == 7'd0) dec.kind = rv64d_pkg::r_kind(f3);
				else if (f7 == rv64d_pkg::F7_ALT && f3 == 3'd0) dec.kind = rv64d_pkg::KIND_SUB;
				else if (f7 == rv64d_pkg::F7_ALT && f3 == 3'd5) dec.kind = rv64d_pkg::KIND_SRA;
			end
			rv64d_pkg::OPC_OP_IMM: begin
				if (f3 == 3'd1) begin
					if (f6 == 6'd0) dec.kind = rv64d_pkg::KIND_SLLI;
				end else if (f3 == 3'd5) begin
					if (f6 == 6'd0) dec.kind = rv64d_pkg::KIND_SRLI;
					else if (f6 == rv64d_pkg::F6_SRAI) dec.kind = rv64d_pkg::KIND_SRAI;
				end else begin
					dec.kind = rv64d_pkg::i_kind(f3);
				end
				if (f3 == 3'd1 || f3 == 3'd5) begin
					if (dec.kind != rv64d_pkg::KIND_UNREC)
						dec.imm = {26'd0, instruction[25:20]};
				end else begin
					dec.imm = {{20{instruction[31]}}, instruction[31:20]};
				end
			end
			rv64d_pkg::OPC_LOAD: begin
				if (f3 != 3'd7) begin
					dec.kind = rv64d_pkg::KIND_LOAD0 + {3'd0, f3};
					dec.imm  = {{20{instruction[31]}}, instruction[31:20]};
				end
			end
			rv64d_pkg::OPC_JALR: begin
				if (f3 == 3'd0) begin
					dec.kind = rv64d_pkg::KIND_JALR;
					dec.imm  = {{20{instruction[31]}}, instruction[31:20]};
				end
			end
			rv64d_pkg::OPC_STORE: begin
				if (!f3[2]) begin
					dec.kind = rv64d_pkg::KIND_STOR0 + {3'd0, f3};
					dec.imm  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
				end
			end
			rv64d_pkg::OPC_JAL: begin
				dec.kind   = rv64d_pkg::KIND_JAL;
				dec.imm    = {{11{j_imm[20]}}, j_imm};
				dec.branch = 1'b1;
			end
			rv64d_pkg::OPC_LUI: begin
				dec.kind = rv64d_pkg::KIND_LUI;
				dec.imm  = {instruction[31:12], 12'd0};
			end
			rv64d_pkg::OPC_BRANCH: begin
				dec.kind = rv64d_pkg::b_kind(f3);
				if (dec.kind != rv64d_pkg::KIND_UNREC) begin
					dec.imm    = {{19{b_imm[12]}}, b_imm};
					dec.branch = 1'b1;
				end
			end
			default: ;
		endcase
		// divide by four toward zero: add three before the shift when negative
		off_full = ($signed(dec.imm) + (dec.imm[31] ? 32'sd3 : 32'sd0)) >>> 2;
		dec.offset = off_full[rv64d_pkg::LINE_W-1:0];
	end
endmodule

/* rtl/rv64d_search.sv */
`timescale 1ns / 1ps
module rv64d_search #(
	parameter int MAX_LABELS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rv64d_pkg::LINE_W-1:0] key,
	input  logic [$clog2(MAX_LABELS+1)-1:0] used,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_LABELS)-1:0] wr_idx,
	input  logic [rv64d_pkg::LINE_W-1:0] wr_line,
	output logic                         done,
	output logic                         found,
	output logic [$clog2(MAX_LABELS)-1:0] idx
);
	localparam int IW = $clog2(MAX_LABELS);
	localparam int CW = $clog2(MAX_LABELS + 1);

	logic [rv64d_pkg::LINE_W-1:0] mem [MAX_LABELS];
	logic [rv64d_pkg::LINE_W-1:0] rd_q;
	logic [CW-1:0] addr_q;
	logic [CW-1:0] chk_q;
	logic          busy_q;
	logic          rd_vld_q;
	logic [CW-1:0] next_addr;

	assign next_addr = addr_q + CW'(1);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_line;
		rd_q <= mem[addr_q[IW-1:0]];
	end

	// one table entry read per cycle while a search is busy; the registered read is compared with the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rd_vld_q <= 1'b0;
			addr_q   <= '0;
			chk_q    <= '0;
			done     <= 1'b0;
			found    <= 1'b0;
			idx      <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				addr_q   <= '0;
				rd_vld_q <= 1'b0;
				found    <= 1'b0;
				idx      <= '0;
				if (used == '0) begin
					done <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (rd_vld_q && rd_q == key) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					found  <= 1'b1;
					idx    <= chk_q[IW-1:0];
					rd_vld_q <= 1'b0;
				end else if (rd_vld_q && next_addr > used && chk_q + CW'(1) == used) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					rd_vld_q <= 1'b0;
				end else begin
					if (addr_q < used) begin
						chk_q    <= addr_q;
						rd_vld_q <= 1'b1;
						addr_q   <= next_addr;
					end else begin
						rd_vld_q <= 1'b0;
						busy_q   <= 1'b0;
						done     <= 1'b1;
					end
				end
			end
		end
	end
endmodule

/* rtl/rv64i_decode_with_branch_labels.sv */
`timescale 1ns / 1ps
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | instruction
// out     | out_valid | out_stall | op_kind .. label_table_full
//
// the label memory is walked one entry per cycle through its single read port;
// a word that is not a branch or jal walks it once (current line) before its result
// is given, a branch or jal walks twice (current line, then target line)
// reset clears the line count and label count; the label memory needs no clearing
// in_stall is high from acceptance until the result is produced; a new beat may be
// taken while the result waits, but its search starts only once the result is taken
// the result is held in output registers while out_stall is high
module rv64i_decode_with_branch_labels #(
	parameter int MAX_LABELS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instruction,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         op_kind,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src_reg_a,
	output logic [4:0]         src_reg_b,
	output logic signed [31:0] immediate,
	output logic signed [19:0] target_line,
	output logic [5:0]         target_label,
	output logic               target_label_new,
	output logic               backward_new_label,
	output logic               line_has_label,
	output logic [5:0]         line_label,
	output logic               label_table_full
);
	localparam int IW = $clog2(MAX_LABELS);
	localparam int CW = $clog2(MAX_LABELS + 1);
	localparam int LW = rv64d_pkg::LINE_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LINE  = 5'b00010,
		ST_TGT   = 5'b00100,
		ST_ALLOC = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [15:0]  line_q;
	logic [CW-1:0] used_q;
	logic [31:0]  ins_q;
	rv64d_pkg::dec_t dec, dec_q;
	logic [LW-1:0] tline_q;
	logic [LW-1:0] key;
	logic          srch_start;
	logic          srch_done, srch_found;
	logic [IW-1:0] srch_idx;
	logic          wr_en;
	logic [15:0]   line_nx;

	rv64d_decode u_dec (.instruction(ins_q), .dec(dec));

	// the target key must stay put for the whole target walk
	assign key = (state_q == ST_TGT || state_q == ST_ALLOC) ? tline_q :
		{{(LW-16){1'b0}}, line_q};
	assign wr_en = (state_q == ST_ALLOC) && srch_done && !srch_found && (used_q < CW'(MAX_LABELS));

	rv64d_search #(.MAX_LABELS(MAX_LABELS)) u_srch (
		.clk(clk), .arst_n(arst_n), .start(srch_start), .key(key), .used(used_q),
		.wr_en(wr_en), .wr_idx(used_q[IW-1:0]), .wr_line(tline_q),
		.done(srch_done), .found(srch_found), .idx(srch_idx)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign line_nx  = line_q + 16'd1;

	// ST_LINE starts the line search; ST_TGT starts the target search, which ST_ALLOC waits on
	always_comb begin
		srch_start = 1'b0;
		if (state_q == ST_LINE && !out_valid) srch_start = 1'b1;
		if (state_q == ST_TGT) srch_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			line_q    <= '0;
			used_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ins_q   <= instruction;
						line_q  <= line_nx;
						state_q <= ST_LINE;
					end
				end
				ST_LINE: begin
					if (srch_start) begin
						dec_q <= dec;
						tline_q <= LW'(line_q) + dec.offset;
						op_kind   <= dec.kind;
						dest_reg  <= ins_q[11:7];
						src_reg_a <= ins_q[19:15];
						src_reg_b <= ins_q[24:20];
						immediate <= dec.imm;
						target_line <= dec.branch ? (LW'(line_q) + dec.offset) : '0;
						target_label <= '0;
						target_label_new <= 1'b0;
						backward_new_label <= 1'b0;
						label_table_full <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// wait for the line search
					if (srch_done) begin
						line_has_label <= srch_found;
						line_label <= srch_found ? 6'(srch_idx) : 6'd0;
						if (dec_q.branch) state_q <= ST_TGT;
						else begin
							out_valid <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TGT: state_q <= ST_ALLOC;
				ST_ALLOC: begin
					if (srch_done) begin
						if (srch_found) begin
							target_label <= 6'(srch_idx);
						end else if (used_q < CW'(MAX_LABELS)) begin
							target_label <= 6'(used_q);
							target_label_new <= 1'b1;
							backward_new_label <= dec_q.offset[LW-1];
							used_q <= used_q + CW'(1);
						end else begin
							label_table_full <= 1'b1;
						end
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* sim/rv64i_decode_with_branch_labels_tb.sv */
`timescale 1ns / 1ps
module rv64i_decode_with_branch_labels_tb;

	// dense operation numbers, in the order the block encodes them
	typedef enum logic [5:0] {
		OP_ADD, OP_SUB, OP_XOR, OP_OR, OP_AND, OP_SLL, OP_SRL, OP_SRA, OP_SLT, OP_SLTU,
		OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI, OP_SLTI, OP_SLTIU,
		OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU, OP_JALR,
		OP_SB, OP_SH, OP_SW, OP_SD, OP_JAL, OP_LUI,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU, OP_UNREC
	} op_e;

	// opcodes the block does not decode, and the all-zero funct7 and funct6 fields
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
	localparam logic [6:0] F7_ZERO    = 7'b0000000;
	localparam logic [5:0] F6_ZERO    = 6'b000000;

	// funct3 codes used by the directed words
	localparam logic [2:0] F3_ADD   = 3'd0;
	localparam logic [2:0] F3_SLL   = 3'd1;
	localparam logic [2:0] F3_SLT   = 3'd2;
	localparam logic [2:0] F3_SR    = 3'd5;
	localparam logic [2:0] F3_AND   = 3'd7;
	localparam logic [2:0] F3_LWU   = 3'd6;
	localparam logic [2:0] F3_BAD7  = 3'd7;
	localparam logic [2:0] F3_SD    = 3'd3;
	localparam logic [2:0] F3_SBAD  = 3'd4;
	localparam logic [2:0] F3_BEQ   = 3'd0;
	localparam logic [2:0] F3_BNE   = 3'd1;
	localparam logic [2:0] F3_BBAD  = 3'd2;
	localparam logic [2:0] F3_BBAD3 = 3'd3;
	localparam logic [2:0] F3_BLTU  = 3'd6;

	localparam int NUM_LABELS  = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 2 * (NUM_LABELS + 2) + 40;

	typedef struct packed {
		logic [5:0]         kind;
		logic [4:0]         rd;
		logic [4:0]         rs1;
		logic [4:0]         rs2;
		logic signed [31:0] imm;
		logic signed [19:0] tline;
		logic [5:0]         tlabel;
		logic               tnew;
		logic               back;
		logic               has_lab;
		logic [5:0]         lab;
		logic               full;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] instruction = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] op_kind;
	logic [4:0] dest_reg, src_reg_a, src_reg_b;
	logic signed [31:0] immediate;
	logic signed [19:0] target_line;
	logic [5:0] target_label, line_label;
	logic target_label_new, backward_new_label, line_has_label, label_table_full;

	// predictor state: line count, labels in use, target line of each label
	logic [15:0] line_num;
	int          label_count;
	logic [19:0] label_line [NUM_LABELS];

	decoded_t decoded_q [$];
	int  err_count = 0;
	int  cycles = 0;
	int  beats_sent = 0;
	int  beats_seen = 0;
	int  new_labels = 0;
	int  full_hits = 0;
	bit  quiet = 1'b0;     // no idling on either side
	int  hold_req = 0;     // long receiver hold-off, in cycles
	int  out_burst = 0;

	rv64i_decode_with_branch_labels u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .instruction(instruction),
		.out_valid(out_valid), .out_stall(out_stall),
		.op_kind(op_kind), .dest_reg(dest_reg), .src_reg_a(src_reg_a),
		.src_reg_b(src_reg_b), .immediate(immediate), .target_line(target_line),
		.target_label(target_label), .target_label_new(target_label_new),
		.backward_new_label(backward_new_label), .line_has_label(line_has_label),
		.line_label(line_label), .label_table_full(label_table_full)
	);

	always #2 clk = ~clk;

	// run limit, well above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycles, decoded_q.size());
			$display("rv64i_decode_with_branch_labels regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic bit lookup_label(input logic [19:0] line, output int idx);
		idx = 0;
		for (int i = 0; i < label_count && i < NUM_LABELS; i++)
			if (label_line[i] == line) begin
				idx = i;
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic decoded_t decode_and_label(input logic [31:0] w);
		decoded_t d;
		logic [6:0] opc;
		logic [2:0] f3;
		logic [6:0] f7;
		logic [5:0] f6;
		op_e kind;
		bit  jump;
		int  idx, off, tgt;
		opc = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		f6 = w[31:26];
		kind = OP_UNREC;
		jump = 1'b0;
		d = '0;
		d.rd = w[11:7];
		d.rs1 = w[19:15];
		d.rs2 = w[24:20];

		// the label lookup for the current line happens before any allocation
		line_num = line_num + 16'd1;
		if (lookup_label({4'd0, line_num}, idx)) begin
			d.has_lab = 1'b1;
			d.lab = idx[5:0];
		end

		case (opc)
			rv64d_pkg::OPC_OP: begin
				if (f7 == F7_ZERO) begin
					case (f3)
						3'd0: kind = OP_ADD;
						3'd1: kind = OP_SLL;
						3'd2: kind = OP_SLT;
						3'd3: kind = OP_SLTU;
						3'd4: kind = OP_XOR;
						3'd5: kind = OP_SRL;
						3'd6: kind = OP_OR;
						default: kind = OP_AND;
					endcase
				end else if (f7 == rv64d_pkg::F7_ALT && f3 == F3_ADD) begin
					kind = OP_SUB;
				end else if (f7 == rv64d_pkg::F7_ALT && f3 == F3_SR) begin
					kind = OP_SRA;
				end
			end
			rv64d_pkg::OPC_OP_IMM: begin
				case (f3)
					3'd0: kind = OP_ADDI;
					3'd1: if (f6 == F6_ZERO) kind = OP_SLLI;
					3'd2: kind = OP_SLTI;
					3'd3: kind = OP_SLTIU;
					3'd4: kind = OP_XORI;
					3'd5: begin
						if (f6 == F6_ZERO) kind = OP_SRLI;
						else if (f6 == rv64d_pkg::F6_SRAI) kind = OP_SRAI;
					end
					3'd6: kind = OP_ORI;
					default: kind = OP_ANDI;
				endcase
				// shift amounts are unsigned, six bits
				if (kind == OP_SLLI || kind == OP_SRLI || kind == OP_SRAI)
					d.imm = {26'd0, w[25:20]};
				else if (kind != OP_UNREC)
					d.imm = {{20{w[31]}}, w[31:20]};
			end
			rv64d_pkg::OPC_LOAD: begin
				if (f3 != F3_BAD7) begin
					kind = op_e'(OP_LB + f3);
					d.imm = {{20{w[31]}}, w[31:20]};
				end
			end
			rv64d_pkg::OPC_JALR: begin
				if (f3 == F3_ADD) begin
					kind = OP_JALR;
					d.imm = {{20{w[31]}}, w[31:20]};
				end
			end
			rv64d_pkg::OPC_STORE: begin
				if (!f3[2]) begin
					kind = op_e'(OP_SB + f3);
					d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
				end
			end
			rv64d_pkg::OPC_JAL: begin
				kind = OP_JAL;
				d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
				jump = 1'b1;
			end
			rv64d_pkg::OPC_LUI: begin
				kind = OP_LUI;
				d.imm = {w[31:12], 12'd0};
			end
			rv64d_pkg::OPC_BRANCH: begin
				case (f3)
					3'd0: kind = OP_BEQ;
					3'd1: kind = OP_BNE;
					3'd4: kind = OP_BLT;
					3'd5: kind = OP_BGE;
					3'd6: kind = OP_BLTU;
					3'd7: kind = OP_BGEU;
					default: kind = OP_UNREC;
				endcase
				if (kind != OP_UNREC) begin
					d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
					jump = 1'b1;
				end
			end
			default: ;
		endcase
		d.kind = kind;

		if (jump) begin
			off = int'(d.imm) / 4;     // truncates toward zero
			tgt = int'({16'd0, line_num}) + off;
			d.tline = tgt[19:0];
			if (lookup_label(d.tline, idx)) begin
				d.tlabel = idx[5:0];
			end else if (label_count < NUM_LABELS) begin
				label_line[label_count] = d.tline;
				d.tlabel = label_count[5:0];
				label_count++;
				d.tnew = 1'b1;
				d.back = (off < 0);
			end else begin
				d.full = 1'b1;
			end
		end
		return d;
	endfunction

	// ---------------------------------------------------------------
	// word builders
	// ---------------------------------------------------------------
	function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
			input logic [6:0] opc);
		return {f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), opc};
	endfunction

	function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [2:0] f3,
			input logic [6:0] opc);
		return {imm, 5'($urandom), f3, 5'($urandom), opc};
	endfunction

	function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [2:0] f3);
		return {imm[11:5], 5'($urandom), 5'($urandom), f3, imm[4:0], rv64d_pkg::OPC_STORE};
	endfunction

	function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [2:0] f3);
		return {imm[12], imm[10:5], 5'($urandom), 5'($urandom), f3, imm[4:1], imm[11],
			rv64d_pkg::OPC_BRANCH};
	endfunction

	function automatic logic [31:0] enc_j(input logic [20:0] imm);
		return {imm[20], imm[10:1], imm[11], imm[19:12], 5'($urandom), rv64d_pkg::OPC_JAL};
	endfunction

	// a small byte offset near the current line, sometimes off a word boundary
	function automatic int near_offset();
		return ($urandom_range(0, 16) - 8) * 4 + 2 * $urandom_range(0, 1);
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int sel;
		sel = $urandom_range(0, 99);
		w = $urandom;
		if (sel < 35) begin
			if ($urandom_range(0, 9) == 0) w = enc_b({12'($urandom), 1'b0}, 3'($urandom));
			else w = enc_b(13'(near_offset()), 3'($urandom));
		end else if (sel < 50) begin
			if ($urandom_range(0, 4) == 0) w = enc_j({20'($urandom), 1'b0});
			else w = enc_j(21'(near_offset()));
		end else if (sel < 62) begin
			w[6:0] = rv64d_pkg::OPC_OP;
			if ($urandom_range(0, 7) != 0)
				w[31:25] = $urandom_range(0, 1) ? rv64d_pkg::F7_ALT : F7_ZERO;
		end else if (sel < 74) begin
			w[6:0] = rv64d_pkg::OPC_OP_IMM;
			if ($urandom_range(0, 3) != 0)
				w[31:26] = $urandom_range(0, 1) ? rv64d_pkg::F6_SRAI : F6_ZERO;
		end else if (sel < 80) begin
			w[6:0] = rv64d_pkg::OPC_LOAD;
		end else if (sel < 86) begin
			w[6:0] = rv64d_pkg::OPC_STORE;
		end else if (sel < 89) begin
			w[6:0] = rv64d_pkg::OPC_JALR;
		end else if (sel < 92) begin
			w[6:0] = rv64d_pkg::OPC_LUI;
		end
		// the rest stays a fully random word
		return w;
	endfunction

	// ---------------------------------------------------------------
	// driving and checking
	// ---------------------------------------------------------------
	// offer one beat, predict it once it is taken; returns at a falling edge
	task automatic send_word(input logic [31:0] w);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		instruction <= w;
		do @(posedge clk); while (in_stall);
		decoded_q.push_back(decode_and_label(w));
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (decoded_q.size() != 0) @(negedge clk);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
			beats_seen, field, got, want);
		err_count++;
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report_mismatch(field, got, want);
	endtask

	// receiver side: random stall bursts, a long hold-off on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req <= hold_req - 1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (out_burst > 0) begin
			out_stall <= 1'b1;
			out_burst <= out_burst - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			out_burst <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result beats against the oldest prediction
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("unexpected beat", {26'd0, op_kind}, 32'd0);
			end else begin
				want = decoded_q.pop_front();
				if (want.tnew) new_labels++;
				if (want.full) full_hits++;
				check_field("op_kind", 32'(op_kind), 32'(want.kind));
				check_field("dest_reg", 32'(dest_reg), 32'(want.rd));
				check_field("src_reg_a", 32'(src_reg_a), 32'(want.rs1));
				check_field("src_reg_b", 32'(src_reg_b), 32'(want.rs2));
				check_field("immediate", immediate, want.imm);
				check_field("target_line", {12'd0, target_line}, {12'd0, want.tline});
				check_field("target_label", 32'(target_label), 32'(want.tlabel));
				check_field("target_label_new", 32'(target_label_new), 32'(want.tnew));
				check_field("backward_new_label", 32'(backward_new_label), 32'(want.back));
				check_field("line_has_label", 32'(line_has_label), 32'(want.has_lab));
				check_field("line_label", 32'(line_label), 32'(want.lab));
				check_field("label_table_full", 32'(label_table_full), 32'(want.full));
			end
			beats_seen++;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// one word per format, field extremes and each undecodable corner
	task automatic test_directed();
		send_word({F7_ZERO, 5'd31, 5'd31, F3_ADD, 5'd31, rv64d_pkg::OPC_OP});      // add, top regs
		send_word({rv64d_pkg::F7_ALT, 5'd0, 5'd0, F3_ADD, 5'd0, rv64d_pkg::OPC_OP}); // sub
		send_word(enc_r(rv64d_pkg::F7_ALT, F3_SR, rv64d_pkg::OPC_OP));             // sra
		send_word(enc_r(rv64d_pkg::F7_ALT, F3_AND, rv64d_pkg::OPC_OP));            // bad funct3
		send_word(enc_r(7'b0000001, F3_ADD, rv64d_pkg::OPC_OP));                   // bad funct7
		send_word(enc_i(12'h800, F3_ADD, rv64d_pkg::OPC_OP_IMM));                  // addi min
		send_word(enc_i(12'h7ff, F3_SLT, rv64d_pkg::OPC_OP_IMM));                  // slti max
		send_word(enc_i({F6_ZERO, 6'h3f}, F3_SLL, rv64d_pkg::OPC_OP_IMM));         // slli 63
		send_word(enc_i({rv64d_pkg::F6_SRAI, 6'h21}, F3_SR, rv64d_pkg::OPC_OP_IMM)); // srai
		send_word(enc_i({6'h01, 6'h05}, F3_SR, rv64d_pkg::OPC_OP_IMM));            // bad high bits
		send_word(enc_i({rv64d_pkg::F6_SRAI, 6'h05}, F3_SLL, rv64d_pkg::OPC_OP_IMM)); // slli, srai bits
		send_word(enc_i(12'hfff, F3_LWU, rv64d_pkg::OPC_LOAD));                    // lwu
		send_word(enc_i(12'h123, F3_BAD7, rv64d_pkg::OPC_LOAD));                   // load funct3 7
		send_word(enc_i(12'h800, F3_ADD, rv64d_pkg::OPC_JALR));                    // jalr
		send_word(enc_i(12'h001, F3_SLL, rv64d_pkg::OPC_JALR));                    // jalr bad funct3
		send_word(enc_s(12'h800, F3_SD));                                          // sd negative
		send_word(enc_s(12'h7ff, F3_SBAD));                                        // store funct3 4
		send_word({20'hfffff, 5'd1, rv64d_pkg::OPC_LUI});                          // lui all ones
		send_word(enc_j(21'd0));                                                   // jal zero offset
		send_word(enc_j(21'h100000));                                              // jal most negative
		send_word(enc_b(13'h1ff8, F3_BEQ));                                        // beq back two lines
		send_word(enc_b(13'h1ffa, F3_BNE));                                        // -6 bytes truncates
		send_word(enc_b(13'h0ffe, F3_BLTU));                                       // largest forward
		send_word(enc_b(13'h0008, F3_BBAD));                                       // branch funct3 2
		send_word(enc_b(13'h0008, F3_BBAD3));                                      // branch funct3 3
		send_word({25'h1abcdef, OPC_AUIPC});                                       // auipc
		send_word({25'h0000000, OPC_SYSTEM});                                      // ecall
		send_word(32'hffffffff);
		send_word(32'h00000000);
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) send_word(random_word());
	endtask

	// the receiver holds off while beats keep being offered, so in_stall rises
	task automatic test_output_backpressure();
		hold_req = 400;
		for (int i = 0; i < 12; i++) send_word(random_word());
	endtask

	// sender goes idle until every result is back
	task automatic test_drain_pause();
		release_input();
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// distinct far targets, past the capacity of the label table
	task automatic test_label_fill();
		for (int i = 0; i < NUM_LABELS + 8; i++)
			send_word(enc_j(21'((3000 + 7 * i) * 4)));
		// near targets, forward and backward, once the label table is full
		for (int i = 0; i < 8; i++) send_word(enc_b(13'(near_offset()), F3_BNE));
	endtask

	initial begin
		line_num = '0;
		label_count = 0;
		foreach (label_line[i]) label_line[i] = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_mix(300);
		test_output_backpressure();
		test_random_mix(150);
		test_drain_pause();
		test_label_fill();
		test_random_mix(200);
		// last stretch runs without idling on either side
		quiet = 1'b1;
		test_random_mix(180);
		release_input();
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d beats: all formats, shift and funct corners, %0d new labels,",
			beats_seen, new_labels);
		$display("%0d beats with a full label table, long output hold-off and a drain pause",
			full_hits);
		if (err_count == 0 && decoded_q.size() == 0) begin
			$display("rv64i_decode_with_branch_labels regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", err_count, decoded_q.size());
			$display("rv64i_decode_with_branch_labels regression: fail");
		end
		$finish;
	end

endmodule
